// ----- sv/ipatv_pkg.sv -----
// ipatv_pkg: types, codes and character helpers for the ip address text validator
// used by ip_address_text_validator, ipatv_checker and the testbench; no dependencies

package ipatv_pkg;

    localparam logic [1:0] VERDICT_INVALID = 2'd0;
    localparam logic [1:0] VERDICT_IPV4    = 2'd1;
    localparam logic [1:0] VERDICT_IPV6    = 2'd2;

    localparam logic [1:0] MODE_EITHER = 2'd0;
    localparam logic [1:0] MODE_IPV4   = 2'd1;
    localparam logic [1:0] MODE_IPV6   = 2'd2;

    localparam logic [7:0] CHAR_COLON = 8'h3A;
    localparam logic [7:0] CHAR_DOT   = 8'h2E;

    localparam logic [2:0] LAST_DOT_COUNT = 3'd3;
    localparam logic [1:0] MAX_DEC_DIGITS = 2'd3;
    localparam logic [2:0] MAX_HEX_DIGITS = 3'd4;
    localparam logic [3:0] GROUP_SAT      = 4'd15;
    localparam logic [9:0] OCTET_MAX      = 10'd255;
    localparam logic [4:0] GROUPS_FULL    = 5'd8;
    localparam logic [4:0] GROUPS_SHORT   = 5'd7;

    typedef struct packed {
        logic [2:0] dots_seen;
        logic [1:0] decimal_digits;
        logic [9:0] octet_value;
        logic       v4_still_ok;
        logic [3:0] group_count;
        logic [2:0] hex_digits;
        logic       double_colon_seen;
        logic       previous_was_colon;
        logic       in_v4_tail;
        logic       v6_still_ok;
        logic       at_text_start;
        logic       colon_seen;
        logic       pair_last;
    } track_t;

    localparam track_t TRACK_RESET = '{
        dots_seen:          3'd0,
        decimal_digits:     2'd0,
        octet_value:        10'd0,
        v4_still_ok:        1'b1,
        group_count:        4'd0,
        hex_digits:         3'd0,
        double_colon_seen:  1'b0,
        previous_was_colon: 1'b0,
        in_v4_tail:         1'b0,
        v6_still_ok:        1'b1,
        at_text_start:      1'b1,
        colon_seen:         1'b0,
        pair_last:          1'b0
    };

    // bit 4 flags a hex digit, bits 3:0 hold its value
    function automatic logic [4:0] hex_decode(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39)
        begin
            r = {1'b1, 4'(c - 8'h30)};
        end
        else if (c >= 8'h61 && c <= 8'h66)
        begin
            r = {1'b1, 4'(c - 8'h57)};
        end
        else if (c >= 8'h41 && c <= 8'h46)
        begin
            r = {1'b1, 4'(c - 8'h37)};
        end
        return r;
    endfunction

endpackage

// ----- sv/ip_address_text_validator.sv -----
// ip_address_text_validator: per-character ipv4/ipv6 address text checker
// depends on ipatv_pkg
// a final character is registered in stage 0, and its verdict is registered at the output
// throughput: one character per cycle; input stalls only while a final
// character waits behind a verdict that is itself stalled at the output
// reset: asynchronous, clears the trackers, empties both stages, mode to 0

module ip_address_text_validator
    import ipatv_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [1:0] address_mode,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] char_code,
    input  logic       end_of_text,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [1:0] verdict
);

    logic [1:0] mode_reg;
    logic       s0_valid_reg, s0_valid_next;
    logic [7:0] s0_char_reg;
    logic       s0_last_reg;
    track_t     track_reg, track_next;
    logic       out_valid_reg, out_valid_next;
    logic [1:0] verdict_reg, verdict_next;
    logic       s0_block, s0_fire, in_accept;

    assign cfg_ready = 1'b1;
    assign s0_block  = s0_valid_reg && s0_last_reg && out_valid_reg && out_stall;
    assign s0_fire   = s0_valid_reg && !s0_block;
    assign in_stall  = s0_block;
    assign in_accept = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign verdict   = verdict_reg;

    always_comb
    begin
        s0_valid_next = s0_valid_reg;
        if (in_accept)
        begin
            s0_valid_next = 1'b1;
        end
        else if (s0_fire)
        begin
            s0_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        track_t     st;
        logic [4:0] hx;
        logic [9:0] oct;
        logic       dotted, v4, v6;
        logic [4:0] total;
        st     = track_reg;
        hx     = hex_decode(s0_char_reg);
        oct    = 10'(st.octet_value * 10'd10) + {6'd0, hx[3:0]};
        dotted = 1'b0;
        v4     = 1'b0;
        v6     = 1'b0;
        total  = 5'd0;
        verdict_next = verdict_reg;
        if (s0_fire)
        begin
            if (s0_char_reg == CHAR_COLON)
            begin
                st.colon_seen = 1'b1;
                if (st.in_v4_tail)
                begin
                    st.v6_still_ok = 1'b0;
                end
                else if (st.previous_was_colon)
                begin
                    if (st.double_colon_seen)
                    begin
                        st.v6_still_ok = 1'b0;
                    end
                    st.double_colon_seen = 1'b1;
                    st.pair_last = 1'b1;
                end
                else if (st.hex_digits == 3'd0)
                begin
                    if (!st.at_text_start)
                    begin
                        st.v6_still_ok = 1'b0;
                    end
                    st.pair_last = 1'b0;
                end
                else
                begin
                    if (st.group_count < GROUP_SAT)
                    begin
                        st.group_count = st.group_count + 4'd1;
                    end
                    st.hex_digits = 3'd0;
                    st.pair_last = 1'b0;
                end
                st.previous_was_colon = 1'b1;
                if (!st.in_v4_tail)
                begin
                    st.dots_seen      = 3'd0;
                    st.decimal_digits = 2'd0;
                    st.octet_value    = 10'd0;
                    st.v4_still_ok    = 1'b1;
                end
                st.at_text_start = 1'b0;
            end
            else
            begin
                // a lone leading colon is fatal
                if (st.previous_was_colon && !st.pair_last && st.group_count == 4'd0)
                begin
                    st.v6_still_ok = 1'b0;
                end
                st.previous_was_colon = 1'b0;
                st.pair_last = 1'b0;
                if (s0_char_reg == CHAR_DOT)
                begin
                    if (!st.in_v4_tail)
                    begin
                        if (st.colon_seen && st.v4_still_ok && st.decimal_digits != 2'd0)
                        begin
                            st.in_v4_tail = 1'b1;
                        end
                        else
                        begin
                            st.v6_still_ok = 1'b0;
                        end
                    end
                    if (st.decimal_digits == 2'd0 || st.dots_seen >= LAST_DOT_COUNT)
                    begin
                        st.v4_still_ok = 1'b0;
                    end
                    else
                    begin
                        st.dots_seen      = st.dots_seen + 3'd1;
                        st.decimal_digits = 2'd0;
                        st.octet_value    = 10'd0;
                    end
                end
                else if (hx[4])
                begin
                    if (!st.in_v4_tail)
                    begin
                        if (st.hex_digits >= MAX_HEX_DIGITS)
                        begin
                            st.v6_still_ok = 1'b0;
                        end
                        else
                        begin
                            st.hex_digits = st.hex_digits + 3'd1;
                        end
                    end
                    if (hx[3:0] > 4'd9 || st.decimal_digits >= MAX_DEC_DIGITS)
                    begin
                        st.v4_still_ok = 1'b0;
                    end
                    else
                    begin
                        st.octet_value    = oct;
                        st.decimal_digits = st.decimal_digits + 2'd1;
                        if (oct > OCTET_MAX)
                        begin
                            st.v4_still_ok = 1'b0;
                        end
                    end
                end
                else
                begin
                    st.v4_still_ok = 1'b0;
                    st.v6_still_ok = 1'b0;
                end
                if (st.in_v4_tail && !st.v4_still_ok)
                begin
                    st.v6_still_ok = 1'b0;
                end
                st.at_text_start = 1'b0;
            end

            if (s0_last_reg)
            begin
                dotted = st.v4_still_ok && st.dots_seen == LAST_DOT_COUNT
                         && st.decimal_digits != 2'd0;
                v4 = !st.colon_seen && dotted;
                v6 = st.v6_still_ok;
                total = {1'b0, st.group_count};
                if (st.previous_was_colon)
                begin
                    if (!st.pair_last)
                    begin
                        v6 = 1'b0;
                    end
                end
                else if (st.in_v4_tail)
                begin
                    if (!dotted)
                    begin
                        v6 = 1'b0;
                    end
                    total = total + 5'd2;
                end
                else
                begin
                    if (st.hex_digits == 3'd0)
                    begin
                        v6 = 1'b0;
                    end
                    total = total + 5'd1;
                end
                if (st.double_colon_seen ? (total > GROUPS_SHORT) : (total != GROUPS_FULL))
                begin
                    v6 = 1'b0;
                end
                case (mode_reg)
                    MODE_IPV4:
                    begin
                        verdict_next = v4 ? VERDICT_IPV4 : VERDICT_INVALID;
                    end
                    MODE_IPV6:
                    begin
                        verdict_next = v6 ? VERDICT_IPV6 : VERDICT_INVALID;
                    end
                    default:
                    begin
                        verdict_next = v4 ? VERDICT_IPV4 : (v6 ? VERDICT_IPV6 : VERDICT_INVALID);
                    end
                endcase
                st = TRACK_RESET;
            end
        end
        track_next = st;
    end

    always_comb
    begin
        out_valid_next = out_valid_reg && out_stall;
        if (s0_fire && s0_last_reg)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= MODE_EITHER;
            s0_valid_reg  <= 1'b0;
            track_reg     <= TRACK_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                mode_reg <= address_mode;
            end
            s0_valid_reg  <= s0_valid_next;
            track_reg     <= track_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s0_char_reg <= char_code;
            s0_last_reg <= end_of_text;
        end
        verdict_reg <= verdict_next;
    end

endmodule

// ----- sv/ipatv_checker.sv -----
// ipatv_checker: port-level assertions for ip_address_text_validator
// depends on ipatv_pkg; bound to the top level below

module ipatv_checker
    import ipatv_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_stall,
    input logic       end_of_text,
    input logic       out_valid,
    input logic       out_stall,
    input logic [1:0] verdict
);

    // stalled verdict holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(verdict))
        else $error("stalled verdict changed or dropped");

    // verdict is always a defined code
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (verdict == VERDICT_INVALID || verdict == VERDICT_IPV4
                       || verdict == VERDICT_IPV6))
        else $error("undefined verdict code");

    // input only stalls behind a stalled verdict
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled without output backpressure");

    // with no backpressure the input never stalls
    assert property (@(posedge clk) disable iff (!rst_n)
        !out_stall |=> !in_stall || $past(in_valid && end_of_text) || out_stall)
        else $error("input stalled after free output");

endmodule

bind ip_address_text_validator ipatv_checker u_ipatv_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .end_of_text (end_of_text),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .verdict     (verdict)
);

// ----- tb/ip_address_text_validator_test.sv -----
// ip_address_text_validator_test: self-checking testbench for ip_address_text_validator
// random and directed address texts, verdicts predicted in-bench and compared in order
// depends on ipatv_pkg and ip_address_text_validator

module ip_address_text_validator_test
    import ipatv_pkg::*;
();

    localparam logic [1:0] MODE_EITHER_ALIAS = 2'd3;
    localparam logic [3:0] GROUP_CEILING     = 4'd15;
    localparam int         IDLE_LIMIT        = 4000;
    localparam int         BURST_CHARS       = 94;
    localparam int         PHASE_COUNT       = 8;
    localparam int         LONG_HOLD         = 300;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } char_req_t;

    typedef struct packed {
        logic [2:0] dots;
        logic [1:0] dec_digits;
        logic [9:0] octet;
        logic       v4_ok;
        logic [3:0] groups;
        logic [2:0] hex_digits;
        logic       pair_seen;
        logic       after_colon;
        logic       dotted_tail;
        logic       v6_ok;
        logic       text_start;
        logic       any_colon;
        logic       pair_end;
    } addr_scan_t;

    logic       clk;
    logic       rst_n = 1'b0;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic [1:0] address_mode = MODE_EITHER;
    logic       in_valid = 1'b0;
    logic       in_stall;
    logic [7:0] char_code = 8'd0;
    logic       end_of_text = 1'b0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic [1:0] verdict;

    char_req_t  send_q[$];
    logic [1:0] verdict_q[$];
    logic [7:0] text_buf[$];

    addr_scan_t scan;
    logic [1:0] mode_now = MODE_EITHER;
    int         send_idle = 0;
    int         stall_pct = 0;
    logic       hold_out = 1'b0;
    int         phase_no = -1;
    int         mismatches = 0;
    int         idle_cycles = 0;
    int         predicted;
    char_req_t  next_req;
    logic [1:0] want;

    ip_address_text_validator dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .address_mode (address_mode),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .char_code    (char_code),
        .end_of_text  (end_of_text),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .verdict      (verdict)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // verdict predictor

    function automatic int hex_nibble(logic [7:0] c);
        if (c >= "0" && c <= "9")
            return int'(c) - int'("0");
        if (c >= "a" && c <= "f")
            return int'(c) - int'("a") + 10;
        if (c >= "A" && c <= "F")
            return int'(c) - int'("A") + 10;
        return -1;
    endfunction

    function automatic void restart_octets();
        scan.dots = 3'd0;
        scan.dec_digits = 2'd0;
        scan.octet = 10'd0;
        scan.v4_ok = 1'b1;
    endfunction

    function automatic void restart_text();
        restart_octets();
        scan.groups = 4'd0;
        scan.hex_digits = 3'd0;
        scan.pair_seen = 1'b0;
        scan.after_colon = 1'b0;
        scan.dotted_tail = 1'b0;
        scan.v6_ok = 1'b1;
        scan.text_start = 1'b1;
        scan.any_colon = 1'b0;
        scan.pair_end = 1'b0;
    endfunction

    function automatic logic dotted_done();
        return scan.v4_ok && scan.dots == 3'd3 && scan.dec_digits != 2'd0;
    endfunction

    // returns the verdict on the final character, -1 otherwise
    function automatic int step_address(logic [7:0] c, logic last);
        int         hv;
        int         total;
        logic       v4;
        logic       v6;
        logic [1:0] v;
        hv = hex_nibble(c);
        if (c == CHAR_COLON)
        begin
            scan.any_colon = 1'b1;
            if (scan.dotted_tail)
                scan.v6_ok = 1'b0;
            else if (scan.after_colon)
            begin
                if (scan.pair_seen)
                    scan.v6_ok = 1'b0;
                scan.pair_seen = 1'b1;
                scan.pair_end = 1'b1;
            end
            else if (scan.hex_digits == 3'd0)
            begin
                if (!scan.text_start)
                    scan.v6_ok = 1'b0;
                scan.pair_end = 1'b0;
            end
            else
            begin
                if (scan.groups < GROUP_CEILING)
                    scan.groups = scan.groups + 4'd1;
                scan.hex_digits = 3'd0;
                scan.pair_end = 1'b0;
            end
            scan.after_colon = 1'b1;
            if (!scan.dotted_tail)
                restart_octets();
            scan.text_start = 1'b0;
        end
        else
        begin
            // a lone leading colon fails once anything else follows
            if (scan.after_colon && !scan.pair_end && scan.groups == 4'd0)
                scan.v6_ok = 1'b0;
            scan.after_colon = 1'b0;
            scan.pair_end = 1'b0;
            if (c == CHAR_DOT)
            begin
                if (!scan.dotted_tail)
                begin
                    if (scan.any_colon && scan.v4_ok && scan.dec_digits != 2'd0)
                        scan.dotted_tail = 1'b1;
                    else
                        scan.v6_ok = 1'b0;
                end
                if (scan.dec_digits == 2'd0 || scan.dots >= 3'd3)
                    scan.v4_ok = 1'b0;
                else
                begin
                    scan.dots = scan.dots + 3'd1;
                    scan.dec_digits = 2'd0;
                    scan.octet = 10'd0;
                end
            end
            else if (hv >= 0)
            begin
                if (!scan.dotted_tail)
                begin
                    if (scan.hex_digits >= 3'd4)
                        scan.v6_ok = 1'b0;
                    else
                        scan.hex_digits = scan.hex_digits + 3'd1;
                end
                if (hv > 9 || scan.dec_digits >= 2'd3)
                    scan.v4_ok = 1'b0;
                else
                begin
                    scan.octet = scan.octet * 10'd10 + 10'(hv);
                    scan.dec_digits = scan.dec_digits + 2'd1;
                    if (scan.octet > 10'd255)
                        scan.v4_ok = 1'b0;
                end
            end
            else
            begin
                scan.v4_ok = 1'b0;
                scan.v6_ok = 1'b0;
            end
            if (scan.dotted_tail && !scan.v4_ok)
                scan.v6_ok = 1'b0;
            scan.text_start = 1'b0;
        end
        if (!last)
            return -1;

        v4 = !scan.any_colon && dotted_done();
        v6 = scan.v6_ok;
        total = int'(scan.groups);
        if (scan.after_colon)
        begin
            if (!scan.pair_end)
                v6 = 1'b0;
        end
        else if (scan.dotted_tail)
        begin
            if (!dotted_done())
                v6 = 1'b0;
            total = total + 2;
        end
        else
        begin
            if (scan.hex_digits == 3'd0)
                v6 = 1'b0;
            total = total + 1;
        end
        if (v6)
            v6 = scan.pair_seen ? (total <= 7) : (total == 8);

        if (mode_now == MODE_IPV4)
            v = v4 ? VERDICT_IPV4 : VERDICT_INVALID;
        else if (mode_now == MODE_IPV6)
            v = v6 ? VERDICT_IPV6 : VERDICT_INVALID;
        else
            v = v4 ? VERDICT_IPV4 : (v6 ? VERDICT_IPV6 : VERDICT_INVALID);
        restart_text();
        return int'(v);
    endfunction

    // text builders

    function automatic logic [7:0] hex_char();
        int r;
        r = $urandom_range(0, 21);
        if (r < 10)
            return 8'("0" + r);
        if (r < 16)
            return 8'("a" + r - 10);
        return 8'("A" + r - 16);
    endfunction

    function automatic logic [7:0] pick_char();
        int r;
        r = $urandom_range(0, 9);
        case (r)
            0, 1: return 8'("0" + $urandom_range(0, 9));
            2: return hex_char();
            3, 4: return CHAR_COLON;
            5: return CHAR_DOT;
            6: return ($urandom_range(0, 1) != 0) ? 8'h67 : 8'h2F;
            7: return ($urandom_range(0, 1) != 0) ? 8'h00 : 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic put_str(string s);
        int i;
        for (i = 0; i < s.len(); i++)
            text_buf.push_back(s[i]);
    endtask

    task automatic put_octet();
        int v;
        int d;
        int w;
        int p;
        int i;
        v = $urandom_range(0, 19);
        if (v == 0)
            v = $urandom_range(256, 999);
        else if (v == 1)
            v = 255;
        else if (v == 2)
            v = 0;
        else
            v = $urandom_range(0, 255);
        d = (v >= 100) ? 3 : ((v >= 10) ? 2 : 1);
        w = $urandom_range(d, 3);
        p = 1;
        for (i = 1; i < w; i++)
            p = p * 10;
        for (i = 0; i < w; i++)
        begin
            text_buf.push_back(8'("0" + (v / p) % 10));
            p = p / 10;
        end
    endtask

    task automatic put_v4();
        int i;
        for (i = 0; i < 4; i++)
        begin
            if (i != 0)
                text_buf.push_back(CHAR_DOT);
            put_octet();
        end
    endtask

    task automatic put_groups(int n);
        int i;
        int k;
        for (i = 0; i < n; i++)
        begin
            if (i != 0)
                text_buf.push_back(CHAR_COLON);
            for (k = $urandom_range(1, 4); k > 0; k--)
                text_buf.push_back(hex_char());
        end
    endtask

    task automatic put_v6();
        logic tail;
        int   slots;
        int   explicit_n;
        int   left_n;
        int   right_n;
        tail = ($urandom_range(0, 3) == 0);
        slots = tail ? 6 : 8;
        if ($urandom_range(0, 1) == 0)
        begin
            put_groups(slots);
            if (tail)
            begin
                text_buf.push_back(CHAR_COLON);
                put_v4();
            end
        end
        else
        begin
            explicit_n = $urandom_range(0, slots - 1);
            left_n = $urandom_range(0, explicit_n);
            right_n = explicit_n - left_n;
            put_groups(left_n);
            put_str("::");
            put_groups(right_n);
            if (tail)
            begin
                if (right_n != 0)
                    text_buf.push_back(CHAR_COLON);
                put_v4();
            end
        end
    endtask

    task automatic mutate_text();
        int pos;
        pos = $urandom_range(0, text_buf.size() - 1);
        case ($urandom_range(0, 6))
            0: text_buf[pos] = pick_char();
            1:
            begin
                if (text_buf.size() > 1)
                    text_buf.delete(pos);
            end
            2: text_buf.insert(pos, text_buf[pos]);
            3: text_buf.push_front(CHAR_COLON);
            4: text_buf.push_back(CHAR_COLON);
            5: text_buf.insert(pos, CHAR_DOT);
            default: text_buf.insert(pos, pick_char());
        endcase
    endtask

    task automatic queue_text();
        int i;
        char_req_t r;
        for (i = 0; i < text_buf.size(); i++)
        begin
            r.ch = text_buf[i];
            r.last = (i == text_buf.size() - 1);
            send_q.push_back(r);
        end
        text_buf.delete();
    endtask

    task automatic make_text();
        int kind;
        int n;
        kind = $urandom_range(0, 99);
        if (kind < 10)
        begin
            for (n = $urandom_range(1, 10); n > 0; n--)
                text_buf.push_back(pick_char());
        end
        else
        begin
            if ($urandom_range(0, 1) != 0)
                put_v4();
            else
                put_v6();
            if (kind < 35)
            begin
                for (n = $urandom_range(1, 2); n > 0; n--)
                    mutate_text();
            end
        end
    endtask

    task automatic fill_chars(int count);
        int n;
        n = 0;
        while (n < count)
        begin
            make_text();
            n = n + text_buf.size();
            queue_text();
        end
    endtask

    task automatic wait_drained();
        while (send_q.size() != 0 || in_valid || verdict_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_mode(logic [1:0] m);
        @(posedge clk);
        cfg_valid <= 1'b1;
        address_mode <= m;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        mode_now = m;
    endtask

    // character request driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                predicted = step_address(char_code, end_of_text);
                if (predicted >= 0)
                    verdict_q.push_back(predicted[1:0]);
            end
            if (!in_valid || !in_stall)
            begin
                if (send_q.size() != 0 && $urandom_range(0, 99) >= send_idle)
                begin
                    next_req = send_q.pop_front();
                    in_valid <= 1'b1;
                    char_code <= next_req.ch;
                    end_of_text <= next_req.last;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // verdict receiver backpressure
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
            out_stall <= hold_out || ($urandom_range(0, 99) < stall_pct);
    end

    // verdict checker
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (verdict_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("verdict %0d with none pending", verdict);
            end
            else
            begin
                want = verdict_q.pop_front();
                if (verdict !== want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("verdict mismatch: expected %0d, got %0d", want, verdict);
                end
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall)
                || (cfg_valid && cfg_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("status: fail");
                $finish;
            end
        end
    end

    // long receiver hold-off while characters keep coming
    initial
    begin
        wait (phase_no == 5);
        repeat (5) @(posedge clk);
        hold_out <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        hold_out <= 1'b0;
    end

    initial
    begin
        restart_text();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        write_mode(MODE_EITHER);
        put_str("7");
        queue_text();
        put_str("::");
        queue_text();
        text_buf.push_back(8'h00);
        queue_text();
        text_buf.push_back(8'hFF);
        queue_text();
        put_str(":a::");
        queue_text();
        put_str("Ff::1.2.3.4");
        queue_text();
        put_str("9.0.255.1");
        queue_text();
        wait_drained();
        repeat (4) @(posedge clk);

        for (int p = 0; p < PHASE_COUNT; p++)
        begin
            case (p % 4)
                0: write_mode(MODE_EITHER);
                1: write_mode(MODE_IPV4);
                2: write_mode(MODE_IPV6);
                default: write_mode(MODE_EITHER_ALIAS);
            endcase
            case ((p / 2) % 4)
                0:
                begin
                    send_idle = 0;
                    stall_pct = 0;
                end
                1:
                begin
                    send_idle = 53;
                    stall_pct = 0;
                end
                2:
                begin
                    send_idle = 0;
                    stall_pct = 53;
                end
                default:
                begin
                    send_idle = 38;
                    stall_pct = 38;
                end
            endcase
            phase_no = p;
            fill_chars(BURST_CHARS);
            wait_drained();
            fill_chars(BURST_CHARS);
            wait_drained();
            repeat (4) @(posedge clk);
        end

        wait_drained();
        repeat (8) @(posedge clk);
        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// ----- ip_address_text_validator.f -----
sv/ipatv_pkg.sv
sv/ip_address_text_validator.sv
sv/ipatv_checker.sv
tb/ip_address_text_validator_test.sv
